FILE: sv/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// shared types, codes and helpers of the per-source connection admitter
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

  localparam int ADDR_W   = 32;
  localparam int TICK_W   = 32;
  localparam int LIMIT_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TICK_W-1:0]  ACT_WINDOW_RST = 32'd1000;
  localparam logic [LIMIT_W-1:0] SRC_LIMIT_RST = 5'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_LIMIT  = 2'd1;

  // item modes
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_END     = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_ADMIT = 2'd0,
    VERDICT_LIMIT = 2'd1,
    VERDICT_FULL  = 2'd2,
    VERDICT_END   = 2'd3
  } verdict_e;

  // one session table entry as kept in memory
  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [TICK_W-1:0] start_ticks;
    logic [TICK_W-1:0] log_ticks;
  } slot_entry_t;

  // rate limit for log flags: never logged, clock went back, or old enough
  function automatic logic log_due(input logic [TICK_W-1:0] kept,
                                   input logic [TICK_W-1:0] now,
                                   input logic [TICK_W-1:0] spacing);
    logic [TICK_W-1:0] gap;
    gap = now - kept;
    return (kept == '0) || (now < kept) || (gap >= spacing);
  endfunction

endpackage

`default_nettype wire

FILE: sv/cpa_table.sv
// ----------------------------------------------------------------------------
// cpa_table
// session table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_table #(
  parameter int SLOTS = 16,
  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        rd_en_i,
  input  wire [IdxW-1:0]             rd_addr_i,
  output cpa_pkg::slot_entry_t       rd_data_o,
  input  wire                        wr_en_i,
  input  wire [IdxW-1:0]             wr_addr_i,
  input  wire cpa_pkg::slot_entry_t  wr_data_i
);
  import cpa_pkg::*;

  slot_entry_t mem [SLOTS];
  slot_entry_t rd_q;
  logic        rd_vld_q;
  logic [SLOTS-1:0] vld_q;

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // written-once marks, an unwritten entry reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: sv/per_source_connection_admitter.sv
// ----------------------------------------------------------------------------
// per_source_connection_admitter
// anti-flood admission control over a fixed session table
// ----------------------------------------------------------------------------
// results: a request item sweeps the table entries in order and stops early
//   when the limit is hit; an end item goes straight to its result; both
//   results wait while the output register stays stalled
// scan: the table scan reads one entry per cycle through the single memory
//   read port; a new item is taken only once the result of the last one is
//   loaded into the output register
// reset: rst_ni clears control, busy and table marks, loads config defaults
//   at once; no clearing pass, the block takes items right after reset
`default_nettype none

module per_source_connection_admitter #(
  parameter int SLOTS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // request / end items
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              mode_i,
  input  wire [cpa_pkg::ADDR_W-1:0]        source_addr_i,
  input  wire [cpa_pkg::TICK_W-1:0]        now_ticks_i,
  input  wire [3:0]                        end_slot_i,
  // result items
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [1:0]                       verdict_o,
  output logic [3:0]                       slot_index_o,
  output logic                             log_event_o,
  // configuration writes
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [cpa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [cpa_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import cpa_pkg::*;

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW = $clog2(SLOTS + 1);
  localparam int CmpW = (CntW > LIMIT_W) ? CntW : LIMIT_W;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(SLOTS - 1);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(SLOTS);

  // scan sequencer: idle, read/evaluate sweep, limit hit, final decision,
  // result hand-off into the output register
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [TICK_W-1:0]  act_window_q, act_window_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;

  // current request
  logic [ADDR_W-1:0] req_src_q, req_src_d;
  logic [TICK_W-1:0] req_now_q, req_now_d;

  // scan bookkeeping
  logic [CntW-1:0] iss_q, iss_d;
  logic            ev_valid_q, ev_valid_d;
  logic [IdxW-1:0] ev_idx_q, ev_idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  slot_entry_t     hit_entry_q, hit_entry_d;

  // busy marks live in flops, they change on end items without a table access
  logic [SLOTS-1:0]  busy_q, busy_d;
  logic [TICK_W-1:0] global_log_q, global_log_d;

  // pending result and output register
  verdict_e res_verdict_q, res_verdict_d;
  logic [3:0] res_idx_q, res_idx_d;
  logic res_log_q, res_log_d;
  logic out_valid_q, out_valid_d;
  verdict_e out_verdict_q, out_verdict_d;
  logic [3:0] out_idx_q, out_idx_d;
  logic out_log_q, out_log_d;

  // table port
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  slot_entry_t     rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  slot_entry_t     wr_data;

  // evaluation of the entry that came back from memory
  logic              start_clr;
  logic [TICK_W-1:0] start_eff;
  logic [TICK_W-1:0] age;
  logic              active;
  logic              match;
  logic [CmpW-1:0]   count_inc;
  logic [LIMIT_W-1:0] limit_eff;
  logic              hit;
  logic              hit_due;
  logic              glob_due;
  logic              in_accept;
  logic              cfg_write;

  cpa_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // a future start time is dropped before the activity test
  assign start_clr = rd_data.start_ticks > req_now_q;
  assign start_eff = start_clr ? '0 : rd_data.start_ticks;
  assign age       = req_now_q - start_eff;
  assign active    = busy_q[ev_idx_q] || ((start_eff != '0) && (age < act_window_q));
  assign match     = (rd_data.src_addr == req_src_q);
  // a limit of zero behaves as one
  assign limit_eff = (limit_q == '0) ? LIMIT_W'(1) : limit_q;
  assign count_inc = CmpW'(count_q) + CmpW'(1);
  assign hit       = active && match && (count_inc >= CmpW'(limit_eff));

  assign hit_due  = log_due(hit_entry_q.log_ticks, req_now_q, act_window_q);
  assign glob_due = log_due(global_log_q, req_now_q, act_window_q);

  always_comb begin
    state_d       = state_q;
    act_window_d  = act_window_q;
    limit_d       = limit_q;
    req_src_d     = req_src_q;
    req_now_d     = req_now_q;
    iss_d         = iss_q;
    ev_valid_d    = ev_valid_q;
    ev_idx_d      = ev_idx_q;
    count_d       = count_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    hit_idx_d     = hit_idx_q;
    hit_entry_d   = hit_entry_q;
    busy_d        = busy_q;
    global_log_d  = global_log_q;
    res_verdict_d = res_verdict_q;
    res_idx_d     = res_idx_q;
    res_log_d     = res_log_q;
    out_valid_d   = out_valid_q;
    out_verdict_d = out_verdict_q;
    out_idx_d     = out_idx_q;
    out_log_d     = out_log_q;
    rd_en         = 1'b0;
    rd_addr       = iss_q[IdxW-1:0];
    wr_en         = 1'b0;
    wr_addr       = ev_idx_q;
    wr_data       = '0;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_write) begin
      case (cfg_index_i)
        CFG_ACT_WINDOW: act_window_d = cfg_data_i;
        CFG_SRC_LIMIT:  limit_d      = cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (mode_i == MODE_END) begin
            // out-of-range slot: acknowledged, nothing freed
            if (int'(end_slot_i) < SLOTS) begin
              busy_d[IdxW'(end_slot_i)] = 1'b0;
            end
            res_verdict_d = VERDICT_END;
            res_idx_d     = end_slot_i;
            res_log_d     = 1'b0;
            state_d       = ST_FINISH;
          end else begin
            req_src_d    = source_addr_i;
            // a zero timestamp is taken as one
            req_now_d    = (now_ticks_i == '0) ? TICK_W'(1) : now_ticks_i;
            iss_d        = '0;
            ev_valid_d   = 1'b0;
            count_d      = '0;
            free_found_d = 1'b0;
            state_d      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue the next read, its data is evaluated in the following cycle
        ev_valid_d = 1'b0;
        if (iss_q != SlotsCnt) begin
          rd_en      = 1'b1;
          iss_d      = iss_q + CntW'(1);
          ev_valid_d = 1'b1;
          ev_idx_d   = iss_q[IdxW-1:0];
        end
        if (ev_valid_q) begin
          if (hit) begin
            // limit reached: stop the sweep, later entries stay untouched
            hit_idx_d                 = ev_idx_q;
            hit_entry_d.src_addr      = rd_data.src_addr;
            hit_entry_d.start_ticks   = start_eff;
            hit_entry_d.log_ticks     = rd_data.log_ticks;
            ev_valid_d                = 1'b0;
            state_d                   = ST_HIT;
          end else begin
            if (start_clr) begin
              wr_en               = 1'b1;
              wr_addr             = ev_idx_q;
              wr_data.src_addr    = rd_data.src_addr;
              wr_data.start_ticks = '0;
              wr_data.log_ticks   = rd_data.log_ticks;
            end
            if (active && match) begin
              count_d = count_q + CntW'(1);
            end
            if (!active && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = ev_idx_q;
            end
            if (ev_idx_q == LastIdx) begin
              state_d = ST_DECIDE;
            end
          end
        end
      end

      ST_HIT: begin
        // write back the cleared start time together with the log time
        wr_en   = 1'b1;
        wr_addr = hit_idx_q;
        wr_data = hit_entry_q;
        if (hit_due) begin
          wr_data.log_ticks = req_now_q;
        end
        res_verdict_d = VERDICT_LIMIT;
        res_idx_d     = 4'(hit_idx_q);
        res_log_d     = hit_due;
        state_d       = ST_FINISH;
      end

      ST_DECIDE: begin
        if (free_found_q) begin
          wr_en               = 1'b1;
          wr_addr             = free_idx_q;
          wr_data.src_addr    = req_src_q;
          wr_data.start_ticks = req_now_q;
          wr_data.log_ticks   = '0;
          busy_d[free_idx_q]  = 1'b1;
          res_verdict_d       = VERDICT_ADMIT;
          res_idx_d           = 4'(free_idx_q);
          res_log_d           = 1'b0;
        end else begin
          // table full, global log rate limit
          if (glob_due) begin
            global_log_d = req_now_q;
          end
          res_verdict_d = VERDICT_FULL;
          res_idx_d     = '0;
          res_log_d     = glob_due;
        end
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_verdict_d = res_verdict_q;
          out_idx_d     = res_idx_q;
          out_log_d     = res_log_q;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      act_window_q  <= ACT_WINDOW_RST;
      limit_q       <= SRC_LIMIT_RST;
      req_src_q     <= '0;
      req_now_q     <= '0;
      iss_q         <= '0;
      ev_valid_q    <= 1'b0;
      ev_idx_q      <= '0;
      count_q       <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      hit_idx_q     <= '0;
      hit_entry_q   <= '0;
      busy_q        <= '0;
      global_log_q  <= '0;
      res_verdict_q <= VERDICT_ADMIT;
      res_idx_q     <= '0;
      res_log_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_verdict_q <= VERDICT_ADMIT;
      out_idx_q     <= '0;
      out_log_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      act_window_q  <= act_window_d;
      limit_q       <= limit_d;
      req_src_q     <= req_src_d;
      req_now_q     <= req_now_d;
      iss_q         <= iss_d;
      ev_valid_q    <= ev_valid_d;
      ev_idx_q      <= ev_idx_d;
      count_q       <= count_d;
      free_found_q  <= free_found_d;
      free_idx_q    <= free_idx_d;
      hit_idx_q     <= hit_idx_d;
      hit_entry_q   <= hit_entry_d;
      busy_q        <= busy_d;
      global_log_q  <= global_log_d;
      res_verdict_q <= res_verdict_d;
      res_idx_q     <= res_idx_d;
      res_log_q     <= res_log_d;
      out_valid_q   <= out_valid_d;
      out_verdict_q <= out_verdict_d;
      out_idx_q     <= out_idx_d;
      out_log_q     <= out_log_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = out_verdict_q;
  assign slot_index_o = out_idx_q;
  assign log_event_o  = out_log_q;

endmodule

`default_nettype wire

FILE: sv/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker
// port-level checks of the per-source connection admitter
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [1:0] verdict_o,
  input wire [3:0] slot_index_o,
  input wire       log_event_o
);
  import cpa_pkg::*;

  // an accepted item keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an accepted item");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(verdict_o) && $stable(slot_index_o) &&
       $stable(log_event_o)))
    else $error("stalled result changed");

  // admits and end acknowledgements never raise the log flag
  a_no_log_on_admit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((verdict_o == VERDICT_ADMIT) || (verdict_o == VERDICT_END)))
      |-> !log_event_o)
    else $error("log flag on an admit or end");

  // a full table reports slot zero
  a_full_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (verdict_o == VERDICT_FULL)) |-> (slot_index_o == 4'd0))
    else $error("table full with nonzero slot index");

endmodule

bind per_source_connection_admitter cpa_checker u_cpa_checker (.*);

`default_nettype wire
